// ===== rtl/csm_pkg.sv =====
// Shared types and constants for the contrast stretch mapper.
// Used by csm_smul, csm_sdiv, contrast_stretch_mapper_top and the testbench; depends on nothing.
`timescale 1ns / 1ps

package csm_pkg;

  // Width of a grey level and the widths that follow from it.
  localparam int PixW  = 8;
  localparam int ProdW = 2 * PixW;
  localparam int NumW  = ProdW + 1;
  localparam int CntW  = $clog2(PixW);

  // Item commands.
  localparam logic CmdMeasure = 1'b0;
  localparam logic CmdMap     = 1'b1;

  // Configuration register indexes.
  localparam logic RegOutMin = 1'b0;
  localparam logic RegOutMax = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [PixW-1:0] OutMinReset = '0;
  localparam logic [PixW-1:0] OutMaxReset = '1;

  // Control sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDiv,
    StOut
  } state_e;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ===== rtl/contrast_stretch_mapper_top.sv =====
// Contrast stretch mapper. A measure beat is taken while idle and gives no result.
// A map beat of a measured, non-flat image passes an 8-step shift-add multiplier and
// an 8-step restoring divider, then the result and output registers; the next beat
// is taken once the output register is loaded, so a stalled output holds it off.
// A flat or unmeasured map beat goes straight to the result register. Asynchronous
// active-low reset: out_min 0, out_max 255, lowest 255, highest 0, nothing measured.
`timescale 1ns / 1ps

module contrast_stretch_mapper_top import csm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Item input
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            in_command_i,
  input  logic [PixW-1:0] in_pixel_i,
  input  logic            in_first_i,
  // Result output
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [PixW-1:0] out_level_o,
  output logic            out_flat_o,
  // Configuration writes
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [PixW-1:0] cfg_data_i
);

  state_e           state_q, state_d;
  logic [PixW-1:0]  omin_q, omax_q;
  logic [PixW-1:0]  lowest_q, highest_q;
  logic             seen_q;
  logic [PixW-1:0]  range_q;
  logic [PixW-1:0]  mapmin_q;
  logic             neg_q;
  logic [PixW-1:0]  res_level_q;
  logic             res_flat_q;
  logic [PixW-1:0]  out_level_q;
  logic             out_flat_q;
  logic             out_valid_q;

  logic             in_acc;
  logic             is_map;
  logic             flat_img;
  logic [PixW-1:0]  clamped;
  logic [PixW-1:0]  n_val;
  logic [PixW-1:0]  rng;
  logic             neg;
  logic [PixW-1:0]  mag;
  logic             mul_start;
  logic             div_start;
  logic             res_load_flat;
  logic             res_load_calc;
  logic             out_load;
  logic [ProdW-1:0] prod;
  logic [PixW-1:0]  quot;
  logic [PixW-1:0]  calc_level;
  unit_sts_t        mul_sts;
  unit_sts_t        div_sts;

  // Operands of a map beat, taken from the measured range and the registers.
  always_comb begin
    flat_img = !seen_q || (highest_q <= lowest_q);
    if (in_pixel_i < lowest_q) begin
      clamped = lowest_q;
    end else if (in_pixel_i > highest_q) begin
      clamped = highest_q;
    end else begin
      clamped = in_pixel_i;
    end
    n_val      = clamped - lowest_q;
    rng        = highest_q - lowest_q;
    neg        = (omax_q < omin_q);
    mag        = neg ? (omin_q - omax_q) : (omax_q - omin_q);
    calc_level = neg_q ? (mapmin_q - quot) : (mapmin_q + quot);
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && is_map) begin
          state_d = flat_img ? StOut : StMul;
        end
      end
      StMul: begin
        if (mul_sts.done) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_sts.done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall_o    = (state_q != StIdle);
    in_acc        = in_valid_i && (state_q == StIdle);
    is_map        = (in_command_i == CmdMap);
    mul_start     = in_acc && is_map && !flat_img;
    res_load_flat = in_acc && is_map && flat_img;
    div_start     = (state_q == StMul) && mul_sts.done;
    res_load_calc = (state_q == StDiv) && div_sts.done;
    out_load      = (state_q == StOut) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omin_q <= OutMinReset;
      omax_q <= OutMaxReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegOutMin: omin_q <= cfg_data_i;
        RegOutMax: omax_q <= cfg_data_i;
        default:   omin_q <= omin_q;
      endcase
    end
  end

  // Measured range: a first beat or the first beat since reset restarts it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q  <= '1;
      highest_q <= '0;
      seen_q    <= 1'b0;
    end else if (in_acc && (in_command_i == CmdMeasure)) begin
      seen_q <= 1'b1;
      if (in_first_i || !seen_q) begin
        lowest_q  <= in_pixel_i;
        highest_q <= in_pixel_i;
      end else begin
        if (in_pixel_i < lowest_q) begin
          lowest_q <= in_pixel_i;
        end
        if (in_pixel_i > highest_q) begin
          highest_q <= in_pixel_i;
        end
      end
    end
  end

  // Operands held for the end of the computation.
  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      range_q  <= rng;
      mapmin_q <= omin_q;
      neg_q    <= neg;
    end
  end

  // Result waiting for the output register.
  always_ff @(posedge clk_i) begin
    if (res_load_flat) begin
      res_level_q <= omin_q;
      res_flat_q  <= 1'b1;
    end else if (res_load_calc) begin
      res_level_q <= calc_level;
      res_flat_q  <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_level_q <= res_level_q;
      out_flat_q  <= res_flat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_level_o = out_level_q;
  assign out_flat_o  = out_flat_q;

  // Serial arithmetic: magnitude times offset, then rounded division by the range.
  csm_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mag),
    .b_i     (n_val),
    .prod_o  (prod),
    .sts_o   (mul_sts)
  );

  csm_sdiv u_sdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .prod_i  (prod),
    .range_i (range_q),
    .quot_o  (quot),
    .sts_o   (div_sts)
  );

  // The two serial units never run at the same time.
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

  // A measured range is never inverted.
  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (lowest_q <= highest_q))
    else $error("lowest above highest after a measure");

  // The divider finishing always hands its result to the output stage.
  a_div_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StDiv) && div_sts.done) |=> (state_q == StOut))
    else $error("divider result not passed on");

  // The output register is never overwritten while a stalled beat waits.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("output beat overwritten");

endmodule

// ===== rtl/csm_smul.sv =====
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on csm_pkg.
`timescale 1ns / 1ps

module csm_smul import csm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PixW-1:0]  a_i,
  input  logic [PixW-1:0]  b_i,
  output logic [ProdW-1:0] prod_o,
  output unit_sts_t        sts_o
);

  logic [ProdW-1:0] prod_q, prod_d;
  logic [PixW-1:0]  b_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [PixW:0]    sum;
  logic             last;

  // The low half holds the remaining multiplier bits; the high half accumulates.
  always_comb begin
    sum    = {1'b0, prod_q[ProdW-1:PixW]} + {1'b0, (prod_q[0] ? b_q : '0)};
    prod_d = {sum, prod_q[PixW-1:1]};
    last   = (cnt_q == CntW'(PixW - 1));
  end

  // Sequencing of the eight steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= {{PixW{1'b0}}, a_i};
      b_q    <= b_i;
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o     = prod_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== rtl/csm_sdiv.sv =====
// Restoring divider giving one quotient bit per cycle, with half-up rounding
// folded into the dividend. Depends on csm_pkg.
`timescale 1ns / 1ps

module csm_sdiv import csm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] prod_i,
  input  logic [PixW-1:0]  range_i,
  output logic [PixW-1:0]  quot_o,
  output unit_sts_t        sts_o
);

  logic [PixW:0]   rem_q, rem_d;
  logic [PixW-1:0] lo_q, lo_d;
  logic [PixW:0]   dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [NumW-1:0] num;
  logic [PixW+1:0] trial;
  logic [PixW+1:0] diff;
  logic            ge;
  logic            last;

  // Dividend is 2*prod + range, divisor is 2*range. The quotient is known to
  // fit in eight bits, so the top bits of the dividend start below the divisor.
  always_comb begin
    num   = {prod_i, 1'b0} + NumW'(range_i);
    trial = {rem_q, lo_q[PixW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[PixW:0] : trial[PixW:0];
    lo_d  = {lo_q[PixW-2:0], ge};
    last  = (cnt_q == CntW'(PixW - 1));
  end

  // Sequencing of the eight steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Dividend bits shift out of the low register as quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num[NumW-1:PixW];
      lo_q  <= num[PixW-1:0];
      dvs_q <= {range_i, 1'b0};
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
    end
  end

  assign quot_o     = lo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== verif/tb_contrast_stretch_mapper_top.sv =====
// Self-checking testbench for contrast_stretch_mapper_top: a directed table, then random
// images fed as measure and map passes under four idling phases and several output ranges.
// Depends on csm_pkg and the mapper RTL only.
`timescale 1ns / 1ps

module tb_contrast_stretch_mapper_top;
  import csm_pkg::*;

  // Run limit in clock cycles, far above the slowest correct run.
  localparam int CycleLimit = 400000;
  // Cycles that a map beat may still be in flight after the last result.
  localparam int SettleCycles = 30;
  localparam int RandomItemsPerPhase = 150;

  // How a directed row gets its expected result.
  localparam logic Computed = 1'b0;
  localparam logic Fixed    = 1'b1;

  typedef struct packed {
    logic [PixW-1:0] level;
    logic            flat;
  } level_res_t;

  typedef struct packed {
    logic            cmd;
    logic [PixW-1:0] pix;
    logic            first;
    logic            how;
    logic [PixW-1:0] level;
    logic            flat;
  } dir_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid;
  logic            in_stall_o;
  logic            in_command;
  logic [PixW-1:0] in_pixel;
  logic            in_first;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [PixW-1:0] out_level_o;
  logic            out_flat_o;
  logic            cfg_valid;
  logic            cfg_ready_o;
  logic            cfg_index;
  logic [PixW-1:0] cfg_data;

  // Predictor state: measured range and output range.
  logic [PixW-1:0] meas_lo;
  logic [PixW-1:0] meas_hi;
  logic            meas_seen;
  logic [PixW-1:0] range_out_min;
  logic [PixW-1:0] range_out_max;

  level_res_t expected_levels[$];

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int beats_sent;
  int maps_sent;
  int results_seen;
  int flat_seen;
  int reg_writes;
  int cycles;

  dir_row_t directed_rows [25] = '{
    '{CmdMap,     8'd0,   1'b0, Fixed,    8'd0,   1'b1}, // map before anything is measured
    '{CmdMap,     8'd255, 1'b1, Fixed,    8'd0,   1'b1}, // first is ignored on a map
    '{CmdMeasure, 8'd100, 1'b0, Computed, 8'd0,   1'b0}, // opening measure needs no first
    '{CmdMap,     8'd100, 1'b0, Fixed,    8'd0,   1'b1}, // single-level image is flat
    '{CmdMeasure, 8'd0,   1'b0, Computed, 8'd0,   1'b0}, // widen down to zero
    '{CmdMap,     8'd0,   1'b0, Fixed,    8'd0,   1'b0},
    '{CmdMap,     8'd100, 1'b0, Fixed,    8'd255, 1'b0},
    '{CmdMap,     8'd200, 1'b0, Fixed,    8'd255, 1'b0}, // clamped to the top
    '{CmdMap,     8'd50,  1'b1, Computed, 8'd0,   1'b0}, // exact tie rounds away from zero
    '{CmdMeasure, 8'd255, 1'b1, Computed, 8'd0,   1'b0}, // new image
    '{CmdMeasure, 8'd0,   1'b0, Computed, 8'd0,   1'b0}, // full range
    '{CmdMap,     8'd255, 1'b0, Fixed,    8'd255, 1'b0},
    '{CmdMap,     8'd0,   1'b0, Fixed,    8'd0,   1'b0},
    '{CmdMap,     8'd128, 1'b0, Computed, 8'd0,   1'b0},
    '{CmdMeasure, 8'h55,  1'b1, Computed, 8'd0,   1'b0},
    '{CmdMeasure, 8'hAA,  1'b0, Computed, 8'd0,   1'b0},
    '{CmdMap,     8'h55,  1'b0, Fixed,    8'd0,   1'b0},
    '{CmdMap,     8'hAA,  1'b0, Fixed,    8'd255, 1'b0},
    '{CmdMap,     8'h00,  1'b0, Fixed,    8'd0,   1'b0}, // clamped to the bottom
    '{CmdMap,     8'hFF,  1'b0, Fixed,    8'd255, 1'b0}, // clamped to the top
    '{CmdMap,     8'h7F,  1'b0, Computed, 8'd0,   1'b0},
    '{CmdMeasure, 8'd1,   1'b1, Computed, 8'd0,   1'b0}, // narrowest non-flat range
    '{CmdMeasure, 8'd2,   1'b0, Computed, 8'd0,   1'b0},
    '{CmdMap,     8'd1,   1'b0, Fixed,    8'd0,   1'b0},
    '{CmdMap,     8'd2,   1'b0, Fixed,    8'd255, 1'b0}
  };

  contrast_stretch_mapper_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_command_i(in_command),
    .in_pixel_i  (in_pixel),
    .in_first_i  (in_first),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_level_o (out_level_o),
    .out_flat_o  (out_flat_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stretched level of one pixel against the measured range, rounding half up on the
  // magnitude so that ties go away from zero for inverted ranges too.
  function automatic level_res_t stretch_level(logic [PixW-1:0] pix);
    level_res_t res;
    int lo, hi, x, d, mag, span, q, v;
    lo = meas_lo;
    hi = meas_hi;
    x = pix;
    if (!meas_seen || hi <= lo) begin
      res.level = range_out_min;
      res.flat = 1'b1;
      return res;
    end
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    d = int'(range_out_max) - int'(range_out_min);
    mag = (d < 0) ? -d : d;
    span = hi - lo;
    q = (2 * mag * (x - lo) + span) / (2 * span);
    v = (d < 0) ? int'(range_out_min) - q : int'(range_out_min) + q;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    res.level = v[PixW-1:0];
    res.flat = 1'b0;
    return res;
  endfunction

  // Drive one item beat and, once it is taken, update the predictor. Valid is left high
  // so that a following beat can go straight out; the caller lowers it when idling.
  task automatic send_beat(input logic cmd, input logic [PixW-1:0] pix, input logic first,
                           input logic how, input level_res_t typed);
    level_res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pixel <= pix;
    in_first <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
    if (cmd == CmdMap) begin
      want = (how == Fixed) ? typed : stretch_level(pix);
      expected_levels.push_back(want);
      maps_sent++;
    end else if (first || !meas_seen) begin
      meas_lo = pix;
      meas_hi = pix;
      meas_seen = 1'b1;
    end else begin
      if (pix < meas_lo) meas_lo = pix;
      if (pix > meas_hi) meas_hi = pix;
    end
  endtask

  // Hold the sender off until every expected result has arrived and the block is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write both output-range registers back to back; the block must be idle.
  task automatic set_out_range(input logic [PixW-1:0] lo_level, input logic [PixW-1:0] hi_level);
    cfg_valid <= 1'b1;
    cfg_index <= RegOutMin;
    cfg_data <= lo_level;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    range_out_min = lo_level;
    cfg_index <= RegOutMax;
    cfg_data <= hi_level;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    range_out_max = hi_level;
    cfg_valid <= 1'b0;
    reg_writes += 2;
  endtask

  function automatic logic [PixW-1:0] pick_pixel(int lo, int hi);
    return PixW'($urandom_range(hi, lo));
  endfunction

  // Random images: a measure pass, then a map pass over pixels mostly near the measured
  // range. Now and then a stray beat or a missing first flag breaks the pattern.
  task automatic run_images(input int n_items);
    int start, n, lo, hi, span, k;
    logic [PixW-1:0] pix;
    start = beats_sent;
    while (beats_sent - start < n_items) begin
      n = $urandom_range(12, 1);
      lo = $urandom_range(255, 0);
      case ($urandom_range(3))
        0: span = 0;
        1: span = $urandom_range(8, 1);
        2: span = $urandom_range(80, 1);
        default: span = 255;
      endcase
      hi = (lo + span > 255) ? 255 : lo + span;
      if (span == 255) lo = 0;
      for (k = 0; k < n; k++) begin
        send_beat(CmdMeasure, pick_pixel(lo, hi),
                  (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0),
                  Computed, '0);
      end
      if ($urandom_range(7) == 0)
        send_beat(1'($urandom_range(1)), PixW'($urandom), 1'($urandom_range(1)),
                  Computed, '0);
      n = $urandom_range(12, 1);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(6) == 0) pix = PixW'($urandom);
        else pix = pick_pixel((lo < 4) ? 0 : lo - 4, (hi > 251) ? 255 : hi + 4);
        send_beat(CmdMap, pix, 1'($urandom_range(1)), Computed, '0);
      end
      if ($urandom_range(39) == 0) drain_results();
    end
  endtask

  // Result side: check each taken beat against the oldest expectation, then pick the
  // stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin : check_beat
      level_res_t want;
      results_seen++;
      if (out_flat_o) flat_seen++;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result beat, level %0d flat %0b", $time, out_level_o,
                 out_flat_o);
        errors++;
      end else begin
        want = expected_levels.pop_front();
        if (out_level_o !== want.level) begin
          $display("%0t: level mismatch, expected %0d, actual %0d", $time, want.level,
                   out_level_o);
          errors++;
        end
        if (out_flat_o !== want.flat) begin
          $display("%0t: flat mismatch, expected %0b, actual %0b", $time, want.flat,
                   out_flat_o);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles,
               expected_levels.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus: reset, the directed table, then four idling phases with their own ranges.
  initial begin : stimulus
    int i, ph;
    clk_i = 1'b0;
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CmdMeasure;
    in_pixel <= '0;
    in_first <= 1'b0;
    out_stall_i <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= RegOutMin;
    cfg_data <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    beats_sent = 0;
    maps_sent = 0;
    results_seen = 0;
    flat_seen = 0;
    reg_writes = 0;
    cycles = 0;
    meas_lo = 8'd255;
    meas_hi = 8'd0;
    meas_seen = 1'b0;
    range_out_min = OutMinReset;
    range_out_max = OutMaxReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < 25; i++) begin
      send_beat(directed_rows[i].cmd, directed_rows[i].pix, directed_rows[i].first,
                directed_rows[i].how, {directed_rows[i].level, directed_rows[i].flat});
    end

    for (ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: set_out_range(8'd255, 8'd0);
        1: set_out_range(8'd77, 8'd77);
        2: set_out_range(PixW'($urandom), PixW'($urandom));
        default: set_out_range(8'd0, 8'd255);
      endcase
      send_idle_pct = (ph == 1) ? 77 : (ph == 3) ? 11 : 0;
      recv_stall_pct = (ph == 2) ? 77 : (ph == 3) ? 11 : 0;
      run_images(RandomItemsPerPhase);
    end

    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Ran %0d beats (%0d maps) through four idling phases and five output ranges.",
             beats_sent, maps_sent);
    $display("Checked %0d results, %0d of them flat, after %0d register writes.",
             results_seen, flat_seen, reg_writes);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
